[rtl/bcmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmc_pkg
// Shared widths, register indexes and constants for the Bayer chroma
// classifier.
// ----------------------------------------------------------------------------
package bcmc_pkg;

    localparam int PIX_W          = 8;
    localparam int CHROMA_W       = 8;
    localparam int REG_W          = 24;
    localparam int NUM_REGS       = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_LINES      = 4;
    localparam int COEF_FRAC_BITS = 8;
    localparam int CHROMA_OFFSET  = 127;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_HUE_UPPER_SLOPE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_UPPER_INTERCEPT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOWER_SLOPE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOWER_INTERCEPT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_INNER_SLOPE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_INNER_INTERCEPT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_OUTER_SLOPE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_OUTER_INTERCEPT = 3'd7;

    // line k uses slope register 2k and intercept 2k+1;
    // a set bit means the point must lie on or below the line
    localparam logic [NUM_LINES-1:0] LINE_IS_UPPER = 4'b0101;

    typedef logic signed [REG_W-1:0]    t_coef;
    typedef logic signed [CHROMA_W-1:0] t_chroma;

endpackage

[rtl/bcmc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmc_in_if
// Input channel: one Bayer quad per word.
// ----------------------------------------------------------------------------
interface bcmc_in_if;
    logic                         valid;
    logic                         ready;
    logic [bcmc_pkg::PIX_W-1:0]   red;
    logic [bcmc_pkg::PIX_W-1:0]   green_row;
    logic [bcmc_pkg::PIX_W-1:0]   green_col;
    logic [bcmc_pkg::PIX_W-1:0]   blue;

    modport source (output valid, red, green_row, green_col, blue, input ready);
    modport sink   (input valid, red, green_row, green_col, blue, output ready);
endinterface

[rtl/bcmc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmc_out_if
// Output channel: chroma pair and model membership per word.
// ----------------------------------------------------------------------------
interface bcmc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bcmc_pkg::CHROMA_W-1:0]   chroma_u;
    logic signed [bcmc_pkg::CHROMA_W-1:0]   chroma_v;
    logic                                   in_model;

    modport source (output valid, chroma_u, chroma_v, in_model, input ready);
    modport sink   (input valid, chroma_u, chroma_v, in_model, output ready);
endinterface

[rtl/bayer_chroma_model_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_chroma_model_classifier
// Chroma extraction from a Bayer quad and four-line colour model test.
// ----------------------------------------------------------------------------
// Takes one Bayer quad per word and returns one word per quad: the chroma
// pair u = (red + green_row - 127) >>> 1 and v = (blue + green_col - 127) >>> 1,
// both wrapped to signed 8 bits, and a flag that is set when (u, v) lies on
// or below the hue upper and saturation inner lines and on or above the hue
// lower and saturation outer lines. Each line is slope*u + intercept in
// signed fixed point with COEF_FRAC_BITS fraction bits, compared exactly
// against v scaled by the same amount. Throughput is one word per clock
// while o_res.ready holds. The accepting edge loads stage 1, and the word
// then passes one register in each of the four stages (chroma, multiply,
// add and compare, combine) on its way to the output register. Each stage
// holds its word under back-pressure and takes a new one whenever it is empty
// or being drained, so bubbles collapse and nothing is lost or repeated. The
// eight coefficient registers reset to zero and are written through the
// plain write port; writes should happen only while the pipeline is empty.
// ----------------------------------------------------------------------------
module bayer_chroma_model_classifier #(
    parameter int COEF_FRAC_BITS = bcmc_pkg::COEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [bcmc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bcmc_pkg::REG_W-1:0]        i_cfg_data,
    // streams
    bcmc_in_if.sink                           i_pix,
    bcmc_out_if.source                        o_res
);

    localparam int PROD_W = bcmc_pkg::REG_W + bcmc_pkg::CHROMA_W;   // slope * u
    localparam int LINE_W = PROD_W + 1;                             // + intercept
    localparam int VS_W   = bcmc_pkg::CHROMA_W + COEF_FRAC_BITS;    // v * 2^F
    localparam int SUM_W  = bcmc_pkg::PIX_W + 2;                    // a + b - 127

    // ------------------------------------------------------------------
    // Coefficient registers
    // ------------------------------------------------------------------
    bcmc_pkg::t_coef r_coef [bcmc_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bcmc_pkg::NUM_REGS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when empty or when its word leaves
    // ------------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !r4_valid || o_res.ready;
    assign rdy3 = !r3_valid || rdy4;
    assign rdy2 = !r2_valid || rdy3;
    assign rdy1 = !r1_valid || rdy2;

    assign i_pix.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_valid <= i_pix.valid;
            end
            if (rdy2) begin
                r2_valid <= r1_valid;
            end
            if (rdy3) begin
                r3_valid <= r2_valid;
            end
            if (rdy4) begin
                r4_valid <= r3_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: chroma. Arithmetic >>1 then wrap to 8 bits is bits [8:1].
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]    n_sum_u, n_sum_v;
    bcmc_pkg::t_chroma   r1_u, r1_v;

    assign n_sum_u = {2'b00, i_pix.red} + {2'b00, i_pix.green_row}
                   - SUM_W'(bcmc_pkg::CHROMA_OFFSET);
    assign n_sum_v = {2'b00, i_pix.blue} + {2'b00, i_pix.green_col}
                   - SUM_W'(bcmc_pkg::CHROMA_OFFSET);

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_pix.valid) begin
            r1_u <= n_sum_u[bcmc_pkg::CHROMA_W:1];
            r1_v <= n_sum_v[bcmc_pkg::CHROMA_W:1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: four slope * u products
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] n_prod [bcmc_pkg::NUM_LINES];
    logic signed [PROD_W-1:0] r2_prod [bcmc_pkg::NUM_LINES];
    bcmc_pkg::t_chroma        r2_u, r2_v;

    always_comb begin
        for (int k = 0; k < bcmc_pkg::NUM_LINES; k++) begin
            n_prod[k] = PROD_W'(r_coef[2*k]) * PROD_W'(r1_u);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r1_valid) begin
            r2_prod <= n_prod;
            r2_u    <= r1_u;
            r2_v    <= r1_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add intercept, compare against v * 2^F
    // ------------------------------------------------------------------
    logic signed [LINE_W-1:0]          n_line [bcmc_pkg::NUM_LINES];
    logic signed [VS_W-1:0]            n_vs;
    logic [bcmc_pkg::NUM_LINES-1:0]    n_pass;
    logic [bcmc_pkg::NUM_LINES-1:0]    r3_pass;
    bcmc_pkg::t_chroma                 r3_u, r3_v;

    assign n_vs = {r2_v, {COEF_FRAC_BITS{1'b0}}};

    always_comb begin
        for (int k = 0; k < bcmc_pkg::NUM_LINES; k++) begin
            n_line[k] = LINE_W'(r2_prod[k]) + LINE_W'(r_coef[2*k+1]);
            if (bcmc_pkg::LINE_IS_UPPER[k]) begin
                n_pass[k] = n_line[k] >= LINE_W'(n_vs);
            end else begin
                n_pass[k] = n_line[k] <= LINE_W'(n_vs);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r2_valid) begin
            r3_pass <= n_pass;
            r3_u    <= r2_u;
            r3_v    <= r2_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: combine into the output register
    // ------------------------------------------------------------------
    bcmc_pkg::t_chroma r4_u, r4_v;
    logic              r4_in_model;

    always_ff @(posedge i_clk) begin
        if (rdy4 && r3_valid) begin
            r4_u        <= r3_u;
            r4_v        <= r3_v;
            r4_in_model <= &r3_pass;
        end
    end

    assign o_res.valid    = r4_valid;
    assign o_res.chroma_u = r4_u;
    assign o_res.chroma_v = r4_v;
    assign o_res.in_model = r4_in_model;

endmodule
